### hw/rtl/adaptive_level_normalizer_core_assert.svh
// Assertion macros for the adaptive level normalizer
`ifndef ADAPTIVE_LEVEL_NORMALIZER_CORE_ASSERT_SVH
`define ADAPTIVE_LEVEL_NORMALIZER_CORE_ASSERT_SVH

// same-cycle implication
`define ALN_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define ALN_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### hw/rtl/alnorm_pkg.sv
// Shared types and constants of the adaptive level normalizer
package alnorm_pkg;

    localparam int LEVEL_W     = 16;
    localparam int TIME_W      = 32;
    localparam int INTERVAL_W  = 16;
    localparam int ALPHA_W     = 9;
    localparam int BYTE_W      = 8;
    localparam int OUT_W       = 16;
    localparam int Q15_SHIFT   = 7;
    localparam int DIVIDEND_W  = LEVEL_W + Q15_SHIFT;
    localparam int DIV_CNT_W   = $clog2(DIVIDEND_W);
    localparam int APB_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;

    localparam logic [INTERVAL_W-1:0] INTERVAL_RST  = INTERVAL_W'(1000);
    localparam logic [ALPHA_W-1:0]    ALPHA_RST     = ALPHA_W'(90);
    localparam logic [ALPHA_W-1:0]    ALPHA_ONE     = ALPHA_W'(256);
    localparam logic [BYTE_W-1:0]     WIN_MIN_START = BYTE_W'(200);
    localparam logic [BYTE_W-1:0]     AVG_MAX_START = BYTE_W'(80);
    localparam logic [BYTE_W-1:0]     AVG_MIN_START = BYTE_W'(40);
    localparam logic [OUT_W-1:0]      Q15_ONE       = OUT_W'(32768);

    localparam logic REG_INTERVAL = 1'b0;
    localparam logic REG_ALPHA    = 1'b1;

    typedef struct packed {
        logic [INTERVAL_W-1:0] interval;
        logic [ALPHA_W-1:0]    alpha;
    } t_cfg;

    typedef struct packed {
        logic start;
    } t_div_ctl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

### hw/rtl/alnorm_regs.sv
// APB configuration registers of the adaptive level normalizer
module alnorm_regs (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [alnorm_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [alnorm_pkg::APB_DATA_W-1:0] pwdata,
    output logic [alnorm_pkg::APB_DATA_W-1:0] prdata,
    output logic                              pready,
    output alnorm_pkg::t_cfg                  o_cfg
);
    import alnorm_pkg::*;

    logic [INTERVAL_W-1:0] r_interval;
    logic [ALPHA_W-1:0]    r_alpha;
    logic                  wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_interval <= INTERVAL_RST;
            r_alpha    <= ALPHA_RST;
        end else if (wr_en) begin
            case (paddr[APB_ADDR_W-1])
                REG_INTERVAL: r_interval <= pwdata[INTERVAL_W-1:0];
                REG_ALPHA:    r_alpha    <= pwdata[ALPHA_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[APB_ADDR_W-1])
            REG_INTERVAL: prdata = APB_DATA_W'(r_interval);
            REG_ALPHA:    prdata = APB_DATA_W'(r_alpha);
            default:      prdata = '0;
        endcase
    end

    assign o_cfg.interval = r_interval;
    assign o_cfg.alpha    = r_alpha;

endmodule

### hw/rtl/alnorm_div.sv
// Restoring serial divider, one quotient bit per cycle
`include "adaptive_level_normalizer_core_assert.svh"
module alnorm_div (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  alnorm_pkg::t_div_ctl              i_ctl,
    input  logic [alnorm_pkg::DIVIDEND_W-1:0] i_dividend,
    input  logic [alnorm_pkg::BYTE_W-1:0]     i_divisor,
    output alnorm_pkg::t_div_stat             o_stat,
    output logic [alnorm_pkg::DIVIDEND_W-1:0] o_quotient
);
    import alnorm_pkg::*;

    logic                  r_busy;
    logic                  r_done;
    logic [DIV_CNT_W-1:0]  r_cnt;
    logic [DIVIDEND_W-1:0] r_quo;
    logic [BYTE_W-1:0]     r_rem;
    logic [BYTE_W-1:0]     r_den;
    logic [BYTE_W:0]       rem_sh;
    logic [BYTE_W:0]       rem_sub;
    logic                  q_bit;
    logic [BYTE_W-1:0]     n_rem;

    assign rem_sh  = {r_rem, r_quo[DIVIDEND_W-1]};
    assign rem_sub = rem_sh - {1'b0, r_den};
    assign q_bit   = (rem_sh >= {1'b0, r_den});
    assign n_rem   = q_bit ? rem_sub[BYTE_W-1:0] : rem_sh[BYTE_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CNT_W'(DIVIDEND_W - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_den <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[DIVIDEND_W-2:0], q_bit};
            r_rem <= n_rem;
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quotient  = r_quo;

    `ALN_ASSERT_NXT(a_start_busy, i_clk, i_rst_n, i_ctl.start, r_busy)
    `ALN_ASSERT_IMP(a_done_idle, i_clk, i_rst_n, r_done, !r_busy)
    `ALN_ASSERT_IMP(a_den_nonzero, i_clk, i_rst_n, i_ctl.start, i_divisor != '0)

endmodule

### hw/rtl/adaptive_level_normalizer_core.sv
// Top level of the adaptive level normalizer: sequencer, averaging and output register
//
//  channel   direction  handshake           payload
//  input     in         i_valid / o_ready   i_level_db, i_time_now
//  result    out        o_valid / i_ready   o_intensity
//  config    in         psel/penable/pready paddr, pwdata, prdata
//
// When the averaged extremes update, an item passes S_BLEND_MAX and S_BLEND_MIN before
// S_PREP and the 23-step serial divider; with no positive span the divider is skipped.
// A new item is taken only while the sequencer is idle.
// The result register holds a finished result while the output stalls; the sequencer
// waits for it to drain before loading the next one.
// Reset is synchronous and active low; configuration comes up at its defaults.
`include "adaptive_level_normalizer_core_assert.svh"
module adaptive_level_normalizer_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [alnorm_pkg::LEVEL_W-1:0]    i_level_db,
    input  logic [alnorm_pkg::TIME_W-1:0]     i_time_now,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [alnorm_pkg::OUT_W-1:0]      o_intensity,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [alnorm_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [alnorm_pkg::APB_DATA_W-1:0] pwdata,
    output logic [alnorm_pkg::APB_DATA_W-1:0] prdata,
    output logic                              pready
);
    import alnorm_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE      = 6'b000001,
        S_CHECK     = 6'b000010,
        S_BLEND_MAX = 6'b000100,
        S_BLEND_MIN = 6'b001000,
        S_PREP      = 6'b010000,
        S_DIV       = 6'b100000
    } t_state;

    localparam int PROD_W = 2 * (BYTE_W + 2) + 1;

    t_cfg                  cfg;
    t_div_ctl              div_ctl;
    t_div_stat             div_stat;
    logic [DIVIDEND_W-1:0] quotient;

    t_state                r_state;
    logic [LEVEL_W-1:0]    r_level;
    logic [TIME_W-1:0]     r_time;
    logic [TIME_W-1:0]     r_last;
    logic [BYTE_W-1:0]     r_win_max;
    logic [BYTE_W-1:0]     r_win_min;
    logic [BYTE_W-1:0]     r_tgt_max;
    logic [BYTE_W-1:0]     r_tgt_min;
    logic [BYTE_W-1:0]     r_avg_max;
    logic [BYTE_W-1:0]     r_avg_min;
    logic [OUT_W-1:0]      r_result;
    logic                  r_pending;
    logic                  r_out_valid;
    logic [OUT_W-1:0]      r_intensity;

    logic [BYTE_W-1:0]     whole;
    logic [BYTE_W-1:0]     n_win_max;
    logic [BYTE_W-1:0]     n_win_min;
    logic [TIME_W-1:0]     deadline;
    logic                  update;
    logic [ALPHA_W-1:0]    alpha_sat;
    logic [BYTE_W-1:0]     mul_tgt;
    logic [BYTE_W-1:0]     mul_prev;
    logic signed [BYTE_W+1:0] mul_diff;
    logic signed [PROD_W-1:0] mul_prod;
    logic signed [PROD_W-1:0] blend_sum;
    logic [BYTE_W-1:0]     n_blend;
    logic [LEVEL_W-1:0]    floor_q88;
    logic [LEVEL_W-1:0]    num;
    logic [BYTE_W-1:0]     den;
    logic [OUT_W-1:0]      quo_clamped;
    logic                  load_out;

    alnorm_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    alnorm_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (div_ctl),
        .i_dividend ({num, Q15_SHIFT'(0)}),
        .i_divisor  (den),
        .o_stat     (div_stat),
        .o_quotient (quotient)
    );

    assign o_ready = (r_state == S_IDLE) && !r_pending;

    assign whole     = r_level[LEVEL_W-1 -: BYTE_W];
    assign n_win_max = (whole > r_win_max) ? whole : r_win_max;
    assign n_win_min = (whole < r_win_min) ? whole : r_win_min;
    assign deadline  = r_last + TIME_W'(cfg.interval);
    assign update    = (r_time > deadline);

    assign alpha_sat = (cfg.alpha > ALPHA_ONE) ? ALPHA_ONE : cfg.alpha;

    // prev + (a * (target - prev)) >>> 8, one multiplier shared by both extremes
    assign mul_tgt   = (r_state == S_BLEND_MAX) ? r_tgt_max : r_tgt_min;
    assign mul_prev  = (r_state == S_BLEND_MAX) ? r_avg_max : r_avg_min;
    assign mul_diff  = $signed({2'b00, mul_tgt}) - $signed({2'b00, mul_prev});
    assign mul_prod  = PROD_W'($signed({1'b0, alpha_sat}) * mul_diff);
    assign blend_sum = $signed(PROD_W'(mul_prev)) + (mul_prod >>> BYTE_W);
    assign n_blend   = blend_sum[BYTE_W-1:0];

    assign floor_q88 = {r_avg_min, BYTE_W'(0)};
    assign num       = (r_level > floor_q88) ? (r_level - floor_q88) : '0;
    assign den       = r_avg_max - r_avg_min;

    assign div_ctl.start = (r_state == S_PREP) && (r_avg_max > r_avg_min);

    assign quo_clamped = (quotient > DIVIDEND_W'(Q15_ONE)) ? Q15_ONE : quotient[OUT_W-1:0];

    assign load_out = r_pending && (!r_out_valid || i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_last      <= '0;
            r_win_max   <= '0;
            r_win_min   <= WIN_MIN_START;
            r_avg_max   <= AVG_MAX_START;
            r_avg_min   <= AVG_MIN_START;
            r_pending   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (load_out) begin
                r_out_valid <= 1'b1;
                r_pending   <= 1'b0;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_valid && o_ready) begin
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    if (update) begin
                        r_last    <= r_time;
                        r_win_max <= '0;
                        r_win_min <= WIN_MIN_START;
                        r_state   <= S_BLEND_MAX;
                    end else begin
                        r_win_max <= n_win_max;
                        r_win_min <= n_win_min;
                        r_state   <= S_PREP;
                    end
                end
                S_BLEND_MAX: begin
                    r_avg_max <= n_blend;
                    r_state   <= S_BLEND_MIN;
                end
                S_BLEND_MIN: begin
                    r_avg_min <= n_blend;
                    r_state   <= S_PREP;
                end
                S_PREP: begin
                    if (r_avg_max > r_avg_min) begin
                        r_state <= S_DIV;
                    end else begin
                        r_pending <= 1'b1;
                        r_state   <= S_IDLE;
                    end
                end
                S_DIV: begin
                    if (div_stat.done) begin
                        r_pending <= 1'b1;
                        r_state   <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_level <= i_level_db;
            r_time  <= i_time_now;
        end
        if (r_state == S_CHECK) begin
            r_tgt_max <= n_win_max;
            r_tgt_min <= n_win_min;
        end
        if (r_state == S_PREP) begin
            r_result <= (num != '0) ? Q15_ONE : '0;
        end else if (r_state == S_DIV && div_stat.done) begin
            r_result <= quo_clamped;
        end
        if (load_out) begin
            r_intensity <= r_result;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_intensity = r_intensity;

    `ALN_ASSERT_IMP(a_out_range, i_clk, i_rst_n, o_valid, o_intensity <= Q15_ONE)
    `ALN_ASSERT_NXT(a_accept_check, i_clk, i_rst_n, i_valid && o_ready, r_state == S_CHECK)
    `ALN_ASSERT_IMP(a_div_active, i_clk, i_rst_n, r_state == S_DIV,
        div_stat.busy || div_stat.done)

endmodule

### dv/adaptive_level_normalizer_core_checker.sv
// Checker for the adaptive level normalizer: tracks configuration, predicts and compares intensity
`timescale 1ns / 1ps
module adaptive_level_normalizer_core_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    input  logic                              o_ready,
    input  logic [alnorm_pkg::LEVEL_W-1:0]    i_level_db,
    input  logic [alnorm_pkg::TIME_W-1:0]     i_time_now,
    input  logic                              o_valid,
    input  logic                              i_ready,
    input  logic [alnorm_pkg::OUT_W-1:0]      o_intensity,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [alnorm_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [alnorm_pkg::APB_DATA_W-1:0] pwdata,
    input  logic                              pready,
    output int unsigned                       o_errors,
    output int unsigned                       o_pending
);
    import alnorm_pkg::*;

    logic [INTERVAL_W-1:0] interval;
    logic [ALPHA_W-1:0]    alpha;
    logic [TIME_W-1:0]     last_update;
    logic [BYTE_W-1:0]     win_max;
    logic [BYTE_W-1:0]     win_min;
    logic [BYTE_W-1:0]     avg_max;
    logic [BYTE_W-1:0]     avg_min;
    logic [OUT_W-1:0]      intensity_q[$];
    int unsigned           mismatches = 0;

    function automatic logic [BYTE_W-1:0] blend_byte(input logic [ALPHA_W-1:0] a,
                                                     input logic [BYTE_W-1:0]  target,
                                                     input logic [BYTE_W-1:0]  prev);
        int unsigned acc;
        acc = a * target + (ALPHA_ONE - a) * prev;
        return BYTE_W'(acc >> 8);
    endfunction

    task automatic level_to_intensity(input logic [LEVEL_W-1:0] level,
                                      input logic [TIME_W-1:0] now,
                                      output logic [OUT_W-1:0] intensity);
        logic [BYTE_W-1:0]  whole;
        logic [TIME_W-1:0]  deadline;
        logic [ALPHA_W-1:0] a;
        int unsigned        floor_q88;
        int unsigned        num;
        int unsigned        quot;
        whole = level[LEVEL_W-1:8];
        if (whole > win_max) begin
            win_max = whole;
        end
        if (whole < win_min) begin
            win_min = whole;
        end
        deadline = last_update + TIME_W'(interval);
        if (now > deadline) begin
            a = (alpha > ALPHA_ONE) ? ALPHA_ONE : alpha;
            last_update = now;
            avg_max = blend_byte(a, win_max, avg_max);
            avg_min = blend_byte(a, win_min, avg_min);
            win_max = '0;
            win_min = WIN_MIN_START;
        end
        floor_q88 = int'(avg_min) << 8;
        num = (level > floor_q88) ? level - floor_q88 : 0;
        if (avg_max > avg_min) begin
            quot = (num << Q15_SHIFT) / (int'(avg_max) - int'(avg_min));
            intensity = (quot > Q15_ONE) ? Q15_ONE : OUT_W'(quot);
        end else begin
            intensity = (num > 0) ? Q15_ONE : '0;
        end
    endtask

    always @(posedge i_clk) begin
        logic [OUT_W-1:0] predicted;
        logic [OUT_W-1:0] oldest;
        if (!i_rst_n) begin
            interval    = INTERVAL_RST;
            alpha       = ALPHA_RST;
            last_update = '0;
            win_max     = '0;
            win_min     = WIN_MIN_START;
            avg_max     = AVG_MAX_START;
            avg_min     = AVG_MIN_START;
            intensity_q.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[APB_ADDR_W-1:2])
                    REG_INTERVAL: interval = pwdata[INTERVAL_W-1:0];
                    REG_ALPHA:    alpha    = pwdata[ALPHA_W-1:0];
                    default: ;
                endcase
            end
            if (o_valid && i_ready) begin
                if (intensity_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("%0t: unexpected result transfer, intensity %0d",
                                 $time, o_intensity);
                    end
                end else begin
                    oldest = intensity_q.pop_front();
                    if (oldest !== o_intensity) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("%0t: intensity mismatch, expected %0d, got %0d",
                                     $time, oldest, o_intensity);
                        end
                    end
                end
            end
            if (i_valid && o_ready) begin
                level_to_intensity(i_level_db, i_time_now, predicted);
                intensity_q.push_back(predicted);
            end
        end
        o_errors  <= mismatches;
        o_pending <= intensity_q.size();
    end

endmodule

### dv/adaptive_level_normalizer_core_tb.sv
// Testbench top for the adaptive level normalizer: stimulus, configuration writes and verdict
`timescale 1ns / 1ps
module adaptive_level_normalizer_core_tb;
    import alnorm_pkg::*;

    localparam int unsigned RUN_LIMIT = 1_000_000;
    localparam int unsigned ITEMS_PER_PHASE = 300;
    localparam int unsigned NUM_PHASES = 6;
    localparam logic [APB_ADDR_W-1:0] ADDR_INTERVAL = {REG_INTERVAL, 2'b00};
    localparam logic [APB_ADDR_W-1:0] ADDR_ALPHA    = {REG_ALPHA, 2'b00};

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_valid;
    logic                  o_ready;
    logic [LEVEL_W-1:0]    i_level_db;
    logic [TIME_W-1:0]     i_time_now;
    logic                  o_valid;
    logic                  i_ready;
    logic [OUT_W-1:0]      o_intensity;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    int unsigned           fail_count;
    int unsigned           pending_count;
    int unsigned           cycles = 0;
    bit                    idle_en = 1'b1;
    logic [TIME_W-1:0]     stamp_now;

    adaptive_level_normalizer_core uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_level_db  (i_level_db),
        .i_time_now  (i_time_now),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_intensity (o_intensity),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    adaptive_level_normalizer_core_checker chk (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_level_db  (i_level_db),
        .i_time_now  (i_time_now),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_intensity (o_intensity),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .pready      (pready),
        .o_errors    (fail_count),
        .o_pending   (pending_count)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= RUN_LIMIT) begin
            $display("adaptive_level_normalizer_core_tb: done, errors");
            $finish;
        end
    end

    initial begin
        i_ready <= 1'b1;
        forever begin
            if (idle_en && $urandom_range(0, 3) == 0) begin
                i_ready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge i_clk);
            end else begin
                i_ready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    task automatic send_level(input logic [LEVEL_W-1:0] level, input logic [TIME_W-1:0] stamp);
        if (idle_en && $urandom_range(0, 2) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_level_db <= level;
        i_time_now <= stamp;
        do @(posedge i_clk); while (!o_ready);
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending_count != 0);
    endtask

    task automatic apb_write(input logic [APB_ADDR_W-1:0] addr, input logic [APB_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_config(input logic [INTERVAL_W-1:0] interval,
                              input logic [ALPHA_W-1:0] alpha);
        drain_results();
        apb_write(ADDR_INTERVAL, APB_DATA_W'(interval));
        apb_write(ADDR_ALPHA, APB_DATA_W'(alpha));
    endtask

    task automatic random_phase(input logic [INTERVAL_W-1:0] interval);
        int unsigned         sel;
        logic [LEVEL_W-1:0]  level;
        repeat (ITEMS_PER_PHASE) begin
            sel = $urandom_range(0, 9);
            if (sel < 6) begin
                stamp_now = stamp_now + $urandom_range(0, interval / 3 + 1);
            end else if (sel < 9) begin
                stamp_now = stamp_now + interval + $urandom_range(0, 3) - 1;
            end else begin
                stamp_now = $urandom();
            end
            sel = $urandom_range(0, 9);
            if (sel < 5) begin
                level = {BYTE_W'($urandom_range(20, 140)), BYTE_W'($urandom())};
            end else if (sel < 8) begin
                level = LEVEL_W'($urandom());
            end else if (sel == 8) begin
                level = $urandom_range(0, 1) ? '1 : '0;
            end else begin
                level = {BYTE_W'($urandom()), BYTE_W'(0)};
            end
            send_level(level, stamp_now);
        end
    endtask

    initial begin
        logic [INTERVAL_W-1:0] phase_interval[NUM_PHASES];
        logic [ALPHA_W-1:0]    phase_alpha[NUM_PHASES];
        phase_interval = '{16'd0, 16'd65535, 16'd1000, 16'd50, 16'd7, 16'd300};
        phase_alpha    = '{9'd0, 9'd256, 9'd511, 9'd90, 9'd200, 9'd128};
        phase_interval[4] = $urandom_range(1, 65534);
        phase_alpha[4]    = $urandom_range(0, 511);

        i_rst_n    <= 1'b0;
        i_valid    <= 1'b0;
        i_level_db <= '0;
        i_time_now <= '0;
        psel       <= 1'b0;
        penable    <= 1'b0;
        pwrite     <= 1'b0;
        paddr      <= '0;
        pwdata     <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_level(16'h0000, 32'd0);
        send_level(16'hFFFF, 32'd500);
        send_level(16'h3C80, 32'd1000);
        send_level(16'h2800, 32'd1001);
        send_level(16'h00FF, 32'd1500);
        send_level(16'hFF00, 32'd2003);

        // saturated alpha with an update on each item that advances the time: extremes collapse onto one level
        set_config(16'd0, 9'd300);
        send_level(16'h5000, 32'd2100);
        send_level(16'h5001, 32'd2101);
        send_level(16'h4FFF, 32'd2102);
        send_level(16'h4F00, 32'd2102);
        send_level(16'h0000, 32'd2103);

        // deadline past the top of the counter
        set_config(16'd65535, 9'd128);
        send_level(16'h7FFF, 32'hFFFF_FFF0);
        send_level(16'h8000, 32'h0000_0100);
        send_level(16'h1234, 32'h0000_FFEF);
        send_level(16'hC0DE, 32'h0000_FFF0);
        send_level(16'hFFFF, 32'hFFFF_FFFF);
        send_level(16'h0001, 32'h8000_0000);

        set_config(16'd0, 9'd0);
        send_level(16'hA5A5, 32'h0000_0001);
        send_level(16'h5A5A, 32'h0000_0002);

        stamp_now = 32'h0000_1000;
        for (int p = 0; p < NUM_PHASES; p++) begin
            if (p == NUM_PHASES - 1) begin
                idle_en = 1'b0;
            end
            set_config(phase_interval[p], phase_alpha[p]);
            random_phase(phase_interval[p]);
        end

        drain_results();
        repeat (40) @(posedge i_clk);
        if (fail_count == 0 && pending_count == 0) begin
            $display("adaptive_level_normalizer_core_tb: done, clean");
        end else begin
            $display("adaptive_level_normalizer_core_tb: done, errors");
        end
        $finish;
    end

endmodule

### sim.f
+incdir+hw/rtl
hw/rtl/alnorm_pkg.sv
hw/rtl/alnorm_regs.sv
hw/rtl/alnorm_div.sv
hw/rtl/adaptive_level_normalizer_core.sv
dv/adaptive_level_normalizer_core_checker.sv
dv/adaptive_level_normalizer_core_tb.sv
